// File: rtl/gdf_pkg.sv
// Package for the GF(2) dependency finder: sequencer states, opcodes,
// configuration register indexes and word constants.
// No dependencies.
package gdf_pkg;

    localparam int WORD_BITS = 64;
    localparam int OUT_WORDS_MAX = 4;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_FIND    = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP,
        ST_PROBE_RD,
        ST_PROBE_EV,
        ST_MAT_P,
        ST_MAT_T,
        ST_MAT_W,
        ST_CMB_P,
        ST_CMB_T,
        ST_CMB_W,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EXH
    } state_t;

endpackage

// File: rtl/gdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/gf2_gauss_dependency_finder_unit.sv
// GF(2) dependency finder: elimination sequencer around the matrix and
// combination stores. Depends on gdf_pkg and gdf_ram.
//
// Usage. Input channel (s_*): opcode 0 writes one 64-bit matrix word, opcode 1
// restarts elimination (combination store to identity, pivot marks cleared),
// opcode 2 asks for the next dependency; opcode 3 is ignored. Write and restart
// give no result. A find walks columns high to low and rows low to high; each
// row test steps, reads and evaluates; a pivot-into-target combine reads the
// pivot and target words and writes back their XOR, matrix words up to the
// current column first, then combination words, over the single read port of
// each store. s_ready is high only between requests.
// Result channel (m_*): a find gives ceil(rows_in_use/64) dependency words
// (at most 4, last set on the final one) or one exhausted transfer (found=0,
// last=1). Each word is read, then loaded once the output register is free;
// a stalled receiver simply holds the sequencer. The final word is held
// in the output register, so the next request may be taken while it waits.
// Configuration (cfg_*): always ready, index 0 rows_in_use, 1 cols_in_use.
// Reset: synchronous active-low aresetn; registers go to 256, state is
// exhausted until the first restart. Matrix contents are undefined until
// written; no clearing pass is run.
module gf2_gauss_dependency_finder_unit #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_row_index,
    input  logic [1:0]  s_word_index,
    input  logic [63:0] s_word_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [1:0]  m_out_word_index,
    output logic [63:0] m_dependency_word,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    import gdf_pkg::*;

    localparam int MAT_WORDS  = (MAX_COLS + WORD_BITS - 1) / WORD_BITS;
    localparam int COMB_WORDS = (MAX_ROWS + WORD_BITS - 1) / WORD_BITS;
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int CCW  = $clog2(MAX_COLS + 1);
    localparam int MAW  = $clog2(MAX_ROWS * MAT_WORDS);
    localparam int CAW  = $clog2(MAX_ROWS * COMB_WORDS);
    localparam int NW   = (MAT_WORDS > COMB_WORDS) ? MAT_WORDS : COMB_WORDS;
    localparam int WCW  = $clog2(NW + 1);

    state_t           state_reg, state_next;
    logic [CW-1:0]    scan_col_reg, scan_col_next;
    logic [RCW-1:0]   pivot_row_reg, pivot_row_next;
    logic [RCW-1:0]   target_row_reg, target_row_next;
    logic [RW-1:0]    probe_row_reg, probe_row_next;
    logic             active_reg, active_next;
    logic             exhausted_reg, exhausted_next;
    logic             marks_reg [MAX_ROWS];
    logic             marks_next [MAX_ROWS];
    logic             touched_reg [MAX_ROWS];
    logic             touched_next [MAX_ROWS];
    logic [8:0]       rows_cfg_reg, rows_cfg_next;
    logic [8:0]       cols_cfg_reg, cols_cfg_next;
    logic [WCW-1:0]   wcnt_reg, wcnt_next;
    logic             zero_reg, zero_next;
    logic [63:0]      hold_reg, hold_next;
    logic [2:0]       out_n_reg, out_n_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [1:0]       m_idx_reg, m_idx_next;
    logic [63:0]      m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    logic             mat_we, mat_re, cmb_we, cmb_re;
    logic [MAW-1:0]   mat_waddr, mat_raddr;
    logic [CAW-1:0]   cmb_waddr, cmb_raddr;
    logic [63:0]      mat_wdata, mat_rdata, cmb_wdata, cmb_rdata;

    logic [RCW-1:0]   eff_rows;
    logic [CCW-1:0]   eff_cols;
    logic [WCW-1:0]   col_word;
    logic [5:0]       col_bit;
    logic [63:0]      col_mask;
    logic [2:0]       n_words;
    logic [RW-1:0]    piv_idx;
    logic [63:0]      mat_xor;
    logic [63:0]      cmb_piv, cmb_tgt;
    logic             s_fire, m_fire, out_free;

    function automatic logic [MAW-1:0] mat_addr(logic [RW-1:0] row, logic [WCW-1:0] w);
        return MAW'(int'(row) * MAT_WORDS + int'(w));
    endfunction

    function automatic logic [CAW-1:0] cmb_addr(logic [RW-1:0] row, logic [WCW-1:0] w);
        return CAW'(int'(row) * COMB_WORDS + int'(w));
    endfunction

    function automatic logic [63:0] ident_word(logic [RW-1:0] row, logic [WCW-1:0] w);
        if (32'(row) / WORD_BITS == 32'(w)) begin
            return 64'd1 << (32'(row) % WORD_BITS);
        end
        return 64'd0;
    endfunction

    gdf_ram #(.WIDTH(64), .DEPTH(MAX_ROWS * MAT_WORDS)) u_mat_ram (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .re    (mat_re),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    gdf_ram #(.WIDTH(64), .DEPTH(MAX_ROWS * COMB_WORDS)) u_cmb_ram (
        .aclk  (aclk),
        .we    (cmb_we),
        .waddr (cmb_waddr),
        .wdata (cmb_wdata),
        .re    (cmb_re),
        .raddr (cmb_raddr),
        .rdata (cmb_rdata)
    );

    // Clamped register values
    always_comb begin
        if (rows_cfg_reg == 9'd0) begin
            eff_rows = RCW'(1);
        end else if (32'(rows_cfg_reg) > MAX_ROWS) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(rows_cfg_reg);
        end
        if (cols_cfg_reg == 9'd0) begin
            eff_cols = CCW'(1);
        end else if (32'(cols_cfg_reg) > MAX_COLS) begin
            eff_cols = CCW'(MAX_COLS);
        end else begin
            eff_cols = CCW'(cols_cfg_reg);
        end
    end

    assign col_word = WCW'(32'(scan_col_reg) / WORD_BITS);
    assign col_bit  = 6'(32'(scan_col_reg) % WORD_BITS);
    assign piv_idx  = pivot_row_reg[RW-1:0];
    assign mat_xor  = mat_rdata ^ hold_reg;

    always_comb begin
        if (wcnt_reg != col_word || col_bit == 6'd63) begin
            col_mask = '1;
        end else begin
            col_mask = (64'd1 << (32'(col_bit) + 1)) - 64'd1;
        end
        if ((32'(eff_rows) + WORD_BITS - 1) / WORD_BITS >= OUT_WORDS_MAX) begin
            n_words = 3'(OUT_WORDS_MAX);
        end else begin
            n_words = 3'((32'(eff_rows) + WORD_BITS - 1) / WORD_BITS);
        end
    end

    // Rows never combined into still read as their identity row
    assign cmb_piv = touched_reg[piv_idx] ? cmb_rdata : ident_word(piv_idx, wcnt_reg);
    assign cmb_tgt = touched_reg[probe_row_reg] ? cmb_rdata
                                                : ident_word(probe_row_reg, wcnt_reg);

    assign s_fire   = s_valid && s_ready;
    assign m_fire   = m_valid_reg && m_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state and register updates
    always_comb begin
        state_next      = state_reg;
        scan_col_next   = scan_col_reg;
        pivot_row_next  = pivot_row_reg;
        target_row_next = target_row_reg;
        probe_row_next  = probe_row_reg;
        active_next     = active_reg;
        exhausted_next  = exhausted_reg;
        marks_next      = marks_reg;
        touched_next    = touched_reg;
        rows_cfg_next   = rows_cfg_reg;
        cols_cfg_next   = cols_cfg_reg;
        wcnt_next       = wcnt_reg;
        zero_next       = zero_reg;
        hold_next       = hold_reg;
        out_n_next      = out_n_reg;
        m_valid_next    = m_fire ? 1'b0 : m_valid_reg;
        m_found_next    = m_found_reg;
        m_idx_next      = m_idx_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROWS: rows_cfg_next = cfg_data;
                CFG_COLS: cols_cfg_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_opcode)
                        OP_RESTART: begin
                            marks_next      = '{default: 1'b0};
                            touched_next    = '{default: 1'b0};
                            scan_col_next   = CW'(eff_cols - CCW'(1));
                            pivot_row_next  = '0;
                            target_row_next = '0;
                            active_next     = 1'b0;
                            exhausted_next  = 1'b0;
                        end
                        OP_FIND: state_next = ST_STEP;
                        default: ;
                    endcase
                end
            end
            ST_STEP: begin
                if (exhausted_reg) begin
                    state_next = ST_EXH;
                end else if (!active_reg) begin
                    if (32'(scan_col_reg) >= 32'(eff_cols) || pivot_row_reg >= eff_rows) begin
                        if (scan_col_reg == '0) begin
                            exhausted_next = 1'b1;
                        end else begin
                            scan_col_next  = scan_col_reg - CW'(1);
                            pivot_row_next = '0;
                        end
                    end else if (marks_reg[piv_idx]) begin
                        pivot_row_next = pivot_row_reg + RCW'(1);
                    end else begin
                        probe_row_next = piv_idx;
                        state_next     = ST_PROBE_RD;
                    end
                end else begin
                    if (target_row_reg >= eff_rows) begin
                        marks_next[piv_idx] = 1'b1;
                        active_next         = 1'b0;
                        pivot_row_next      = pivot_row_reg + RCW'(1);
                    end else begin
                        target_row_next = target_row_reg + RCW'(1);
                        if (!marks_reg[target_row_reg[RW-1:0]]) begin
                            probe_row_next = target_row_reg[RW-1:0];
                            state_next     = ST_PROBE_RD;
                        end
                    end
                end
            end
            ST_PROBE_RD: state_next = ST_PROBE_EV;
            ST_PROBE_EV: begin
                state_next = ST_STEP;
                if (!active_reg) begin
                    if (mat_rdata[col_bit]) begin
                        active_next     = 1'b1;
                        target_row_next = pivot_row_reg + RCW'(1);
                    end else begin
                        pivot_row_next = pivot_row_reg + RCW'(1);
                    end
                end else if (mat_rdata[col_bit]) begin
                    wcnt_next  = '0;
                    zero_next  = 1'b1;
                    state_next = ST_MAT_P;
                end
            end
            ST_MAT_P: state_next = ST_MAT_T;
            ST_MAT_T: begin
                hold_next  = mat_rdata;
                state_next = ST_MAT_W;
            end
            ST_MAT_W: begin
                if ((mat_xor & col_mask) != 64'd0) begin
                    zero_next = 1'b0;
                end
                if (wcnt_reg == col_word) begin
                    wcnt_next  = '0;
                    state_next = ST_CMB_P;
                end else begin
                    wcnt_next  = wcnt_reg + WCW'(1);
                    state_next = ST_MAT_P;
                end
            end
            ST_CMB_P: state_next = ST_CMB_T;
            ST_CMB_T: begin
                hold_next  = cmb_piv;
                state_next = ST_CMB_W;
            end
            ST_CMB_W: begin
                if (32'(wcnt_reg) == COMB_WORDS - 1) begin
                    touched_next[probe_row_reg] = 1'b1;
                    wcnt_next = '0;
                    if (zero_reg) begin
                        out_n_next = n_words;
                        state_next = ST_EMIT_RD;
                    end else begin
                        state_next = ST_STEP;
                    end
                end else begin
                    wcnt_next  = wcnt_reg + WCW'(1);
                    state_next = ST_CMB_P;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b1;
                    m_idx_next   = 2'(wcnt_reg);
                    m_data_next  = cmb_tgt;
                    m_last_next  = (32'(wcnt_reg) + 1 == 32'(out_n_reg));
                    if (32'(wcnt_reg) + 1 == 32'(out_n_reg)) begin
                        state_next = ST_IDLE;
                    end else begin
                        wcnt_next  = wcnt_reg + WCW'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EXH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = 1'b0;
                    m_idx_next   = 2'd0;
                    m_data_next  = 64'd0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Store ports and handshake outputs
    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = mat_addr(probe_row_reg, wcnt_reg);
        mat_wdata = mat_xor;
        mat_re    = 1'b0;
        mat_raddr = mat_addr(probe_row_reg, wcnt_reg);
        cmb_we    = 1'b0;
        cmb_waddr = cmb_addr(probe_row_reg, wcnt_reg);
        cmb_wdata = cmb_tgt ^ hold_reg;
        cmb_re    = 1'b0;
        cmb_raddr = cmb_addr(probe_row_reg, wcnt_reg);
        s_ready   = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_opcode == OP_WRITE && 32'(s_row_index) < MAX_ROWS
                        && 32'(s_word_index) < MAT_WORDS) begin
                    mat_we    = 1'b1;
                    mat_waddr = mat_addr(RW'(s_row_index), WCW'(s_word_index));
                    mat_wdata = s_word_data;
                end
            end
            ST_PROBE_RD: begin
                mat_re    = 1'b1;
                mat_raddr = mat_addr(probe_row_reg, col_word);
            end
            ST_MAT_P: begin
                mat_re    = 1'b1;
                mat_raddr = mat_addr(piv_idx, wcnt_reg);
            end
            ST_MAT_T: mat_re = 1'b1;
            ST_MAT_W: mat_we = 1'b1;
            ST_CMB_P: begin
                cmb_re    = 1'b1;
                cmb_raddr = cmb_addr(piv_idx, wcnt_reg);
            end
            ST_CMB_T:   cmb_re = 1'b1;
            ST_CMB_W:   cmb_we = 1'b1;
            ST_EMIT_RD: cmb_re = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_col_reg   <= '0;
            pivot_row_reg  <= '0;
            target_row_reg <= '0;
            active_reg     <= 1'b0;
            exhausted_reg  <= 1'b1;
            marks_reg      <= '{default: 1'b0};
            touched_reg    <= '{default: 1'b0};
            rows_cfg_reg   <= 9'd256;
            cols_cfg_reg   <= 9'd256;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_col_reg   <= scan_col_next;
            pivot_row_reg  <= pivot_row_next;
            target_row_reg <= target_row_next;
            active_reg     <= active_next;
            exhausted_reg  <= exhausted_next;
            marks_reg      <= marks_next;
            touched_reg    <= touched_next;
            rows_cfg_reg   <= rows_cfg_next;
            cols_cfg_reg   <= cols_cfg_next;
            m_valid_reg    <= m_valid_next;
        end
        probe_row_reg <= probe_row_next;
        wcnt_reg      <= wcnt_next;
        zero_reg      <= zero_next;
        hold_reg      <= hold_next;
        out_n_reg     <= out_n_next;
        m_found_reg   <= m_found_next;
        m_idx_reg     <= m_idx_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = m_found_reg;
    assign m_out_word_index  = m_idx_reg;
    assign m_dependency_word = m_data_reg;
    assign m_last            = m_last_reg;

    // Targets always lie below the active pivot
    a_target_after_pivot: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (target_row_reg > pivot_row_reg))
        else $error("target row not after pivot row");

    a_pivot_unmarked: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> !marks_reg[piv_idx])
        else $error("active pivot already marked");

    a_exhausted_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (exhausted_reg && !(s_fire && s_opcode == OP_RESTART)) |=> exhausted_reg)
        else $error("exhausted cleared without restart");

    a_exhausted_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_last_reg && m_idx_reg == 2'd0
                                           && m_data_reg == 64'd0))
        else $error("exhausted transfer carries payload");

endmodule
